>>> hw/rtl/sync_header_frame_receiver_crc16_core_defines.svh
// Assertion macros shared by the frame receiver RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SYNC_HEADER_FRAME_RECEIVER_CRC16_CORE_DEFINES_SVH
`define SYNC_HEADER_FRAME_RECEIVER_CRC16_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SHFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");
`define SHFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: property failed");
`else
`define SHFR_ASSERT(lbl, prop)
`define SHFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/shfr_pkg.sv
package shfr_pkg;

  localparam int unsigned BodyCntW = 9;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [7:0]  CmdWrite = 8'h01;
  localparam logic [7:0]  SyncLead = 8'h55;
  localparam logic [2:0]  SyncLast = 3'd5;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_offset;
    logic [7:0]  command_code;
    logic [15:0] target_address;
    logic [7:0]  payload_length;
    logic        crc_good;
    logic        frame_last;
  } result_t;

  // Expected byte at each header position: 55 AA 00 00 AA 55.
  function automatic logic [7:0] sync_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = 8'h55;
      3'd1:    b = 8'hAA;
      3'd2:    b = 8'h00;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'hAA;
      3'd5:    b = 8'h55;
      default: b = 8'h55;
    endcase
    return b;
  endfunction

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/shfr_in_if.sv
interface shfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/shfr_out_if.sv
interface shfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_offset;
  logic [7:0]  command_code;
  logic [15:0] target_address;
  logic [7:0]  payload_length;
  logic        crc_good;
  logic        frame_last;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_offset,
    output command_code, output target_address, output payload_length,
    output crc_good, output frame_last, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_offset,
    input command_code, input target_address, input payload_length,
    input crc_good, input frame_last, output ready
  );
endinterface

>>> hw/rtl/sync_header_frame_receiver_crc16_core.sv
// Sync-header frame receiver with CRC-16/CCITT-FALSE check.
// The in_chan channel carries one received byte per beat. The receiver hunts
// for the header 55 AA 00 00 AA 55, then reads a command byte, a little-endian
// address, a length byte (used only for the write command), the payload and a
// little-endian CRC. Each payload byte leaves on out_chan as a beat of its own
// together with the frame fields; the high CRC byte produces a frame end beat
// carrying the CRC verdict, and an overlong body produces a drop beat.
// Bytes that cause no result (header, fields, low CRC byte) are simply absorbed.
// Results are registered, in the skid entry while the output register is held.
// Throughput is one byte per cycle while input ready is high; the byte-wide CRC
// step is unrolled XOR logic between the state registers.
// Results sit in an output register backed by one skid entry, so a byte is
// still taken while a result waits. Input ready falls only once both are full,
// and returns as soon as the sink takes a beat.
// Synchronous reset clears the hunt, the body counter, the held fields and both
// output entries, and loads the CRC accumulator with FFFF.
`include "sync_header_frame_receiver_crc16_core_defines.svh"

module sync_header_frame_receiver_crc16_core #(
  parameter int unsigned MAX_BODY_INDEX = 224
) (
  input  logic              clk,
  input  logic              rst_n,
  shfr_in_if.sink           in_chan,
  shfr_out_if.source        out_chan
);

  localparam logic [shfr_pkg::BodyCntW-1:0] MaxBodyIdx =
    shfr_pkg::BodyCntW'(MAX_BODY_INDEX);

  // Frame state.
  logic [2:0]                      hdr_pos_r, hdr_pos_nxt;
  logic                            in_body_r, in_body_nxt;
  logic [shfr_pkg::BodyCntW-1:0]   body_cnt_r, body_cnt_nxt;
  logic [7:0]                      cmd_r, cmd_nxt;
  logic [15:0]                     addr_r, addr_nxt;
  logic [7:0]                      len_r, len_nxt;
  logic [15:0]                     crc_r, crc_nxt;
  logic [7:0]                      crc_lo_r, crc_lo_nxt;

  // Output register and skid entry.
  shfr_pkg::result_t               out_r, skid_r;
  logic                            out_valid_r, skid_valid_r;

  shfr_pkg::result_t               res;
  logic                            res_valid;
  logic                            accept, pop, drop;
  logic [2:0]                      hunt_pos;
  logic [7:0]                      b;
  logic [shfr_pkg::BodyCntW-1:0]   pay_end;

  assign b       = in_chan.rx_byte;
  assign accept  = in_chan.valid && in_chan.ready;
  assign pop     = out_valid_r && out_chan.ready;
  assign drop    = in_body_r && (body_cnt_r > MaxBodyIdx);
  assign pay_end = shfr_pkg::BodyCntW'(4) + shfr_pkg::BodyCntW'(len_r);

  // Positions six and seven cannot occur, but they restart the hunt if they do.
  // After a drop the offending byte is hunted from the first position.
  always_comb begin
    if (drop || hdr_pos_r > shfr_pkg::SyncLast) begin
      hunt_pos = 3'd0;
    end else begin
      hunt_pos = hdr_pos_r;
    end
  end

  always_comb begin
    hdr_pos_nxt  = hdr_pos_r;
    in_body_nxt  = in_body_r;
    body_cnt_nxt = body_cnt_r;
    cmd_nxt      = cmd_r;
    addr_nxt     = addr_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;

    res_valid          = 1'b0;
    res.result_kind    = shfr_pkg::KIND_PAYLOAD;
    res.payload_byte   = 8'h00;
    res.payload_offset = 8'h00;
    res.command_code   = cmd_r;
    res.target_address = addr_r;
    res.payload_length = len_r;
    res.crc_good       = 1'b0;
    res.frame_last     = 1'b0;

    if (!in_body_r || drop) begin
      if (drop) begin
        // Overlong body: close the frame and feed this byte to the hunt.
        res_valid       = 1'b1;
        res.result_kind = shfr_pkg::KIND_DROP;
        res.frame_last  = 1'b1;
        in_body_nxt     = 1'b0;
        body_cnt_nxt    = '0;
      end
      if (b == shfr_pkg::sync_byte(hunt_pos)) begin
        if (hunt_pos == shfr_pkg::SyncLast) begin
          hdr_pos_nxt  = 3'd0;
          in_body_nxt  = 1'b1;
          body_cnt_nxt = '0;
          crc_nxt      = shfr_pkg::CrcInit;
        end else begin
          hdr_pos_nxt = hunt_pos + 3'd1;
        end
      end else begin
        hdr_pos_nxt = (b == shfr_pkg::SyncLead) ? 3'd1 : 3'd0;
      end
    end else begin
      body_cnt_nxt = body_cnt_r + shfr_pkg::BodyCntW'(1);
      if (body_cnt_r < shfr_pkg::BodyCntW'(4)) begin
        crc_nxt = shfr_pkg::crc16_byte(crc_r, b);
        if (body_cnt_r == shfr_pkg::BodyCntW'(0)) begin
          cmd_nxt = b;
        end else if (body_cnt_r == shfr_pkg::BodyCntW'(1)) begin
          addr_nxt = {addr_r[15:8], b};
        end else if (body_cnt_r == shfr_pkg::BodyCntW'(2)) begin
          addr_nxt = {b, addr_r[7:0]};
        end else begin
          len_nxt = (cmd_r == shfr_pkg::CmdWrite) ? b : 8'h00;
        end
      end else if (body_cnt_r < pay_end) begin
        crc_nxt            = shfr_pkg::crc16_byte(crc_r, b);
        res_valid          = 1'b1;
        res.payload_byte   = b;
        res.payload_offset = body_cnt_r[7:0] - 8'd4;
      end else if (body_cnt_r == pay_end) begin
        crc_lo_nxt = b;
      end else begin
        // High CRC byte closes the frame; hunting resumes at once.
        res_valid       = 1'b1;
        res.result_kind = shfr_pkg::KIND_END;
        res.crc_good    = ({b, crc_lo_r} == crc_r);
        res.frame_last  = 1'b1;
        in_body_nxt     = 1'b0;
        body_cnt_nxt    = '0;
        hdr_pos_nxt     = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r  <= 3'd0;
      in_body_r  <= 1'b0;
      body_cnt_r <= '0;
      cmd_r      <= 8'h00;
      addr_r     <= 16'h0000;
      len_r      <= 8'h00;
      crc_r      <= shfr_pkg::CrcInit;
      crc_lo_r   <= 8'h00;
    end else if (accept) begin
      hdr_pos_r  <= hdr_pos_nxt;
      in_body_r  <= in_body_nxt;
      body_cnt_r <= body_cnt_nxt;
      cmd_r      <= cmd_nxt;
      addr_r     <= addr_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
  end

  // Two-entry output buffer. The skid entry only fills while the output
  // register is held, and input ready drops while it is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      out_valid_r  <= skid_valid_r || (accept && res_valid);
      skid_valid_r <= 1'b0;
    end else if (accept && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept && res_valid) begin
        out_r <= res;
      end
    end else if (accept && res_valid) begin
      skid_r <= res;
    end
  end

  assign in_chan.ready = !skid_valid_r;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_kind    = out_r.result_kind;
  assign out_chan.payload_byte   = out_r.payload_byte;
  assign out_chan.payload_offset = out_r.payload_offset;
  assign out_chan.command_code   = out_r.command_code;
  assign out_chan.target_address = out_r.target_address;
  assign out_chan.payload_length = out_r.payload_length;
  assign out_chan.crc_good       = out_r.crc_good;
  assign out_chan.frame_last     = out_r.frame_last;

  // The skid entry is never occupied without the output register.
  `SHFR_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r)
  // The body counter stops one past the limit, where the next byte drops the frame.
  `SHFR_ASSERT(a_body_cnt_bound, body_cnt_r <= MaxBodyIdx + shfr_pkg::BodyCntW'(1))
  // A dropped frame always leaves the receiver hunting.
  `SHFR_ASSERT_NEXT(a_drop_hunts, accept && drop, !in_body_r)
  // Frame end and drop beats close the frame; payload beats never do.
  `SHFR_ASSERT(a_last_matches_kind,
    !out_valid_r || (out_r.frame_last == (out_r.result_kind != shfr_pkg::KIND_PAYLOAD)))

endmodule
